// ===== rtl/avr_isp_pkg.sv =====
// ----------------------------------------------------------------------------
// avr_isp_pkg
// Shared types, codes and the instruction byte table for the ISP sequencer.
// ----------------------------------------------------------------------------
package avr_isp_pkg;

    typedef enum logic [3:0] {
        OP_ENTER         = 4'd0,
        OP_EXIT          = 4'd1,
        OP_WR_FLASH      = 4'd2,
        OP_COMMIT_FLASH  = 4'd3,
        OP_WR_EEPROM     = 4'd4,
        OP_COMMIT_EEPROM = 4'd5,
        OP_RD_FLASH      = 4'd6,
        OP_RD_EEPROM     = 4'd7,
        OP_SIGNATURE     = 4'd8,
        OP_SPI_BYTE      = 4'd9,
        OP_TICK          = 4'd10
    } op_t;

    typedef enum logic [1:0] {
        EV_REQ  = 2'd0,
        EV_BYTE = 2'd1,
        EV_TICK = 2'd2
    } ev_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PULSE  = 2'd1,
        PH_SETTLE = 2'd2,
        PH_XFER   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SPI   = 2'd0,
        KIND_RESET = 2'd1,
        KIND_DONE  = 2'd2
    } res_kind_t;

    typedef struct packed {
        ev_kind_t    kind;
        op_t         op;
        logic [15:0] address;
        logic [15:0] data;
        logic [7:0]  rx;
    } event_t;

    // configuration port
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;
    localparam logic [1:0] CFG_RESET_PULSE  = 2'd0;
    localparam logic [1:0] CFG_SETTLE       = 2'd1;
    localparam logic [1:0] CFG_BUSY_TIMEOUT = 2'd2;
    localparam logic [1:0] CFG_MAX_ATTEMPTS = 2'd3;

    localparam logic [9:0]  RST_PULSE_TICKS  = 10'd5;
    localparam logic [16:0] RST_SETTLE_TICKS = 17'd20000;
    localparam logic [16:0] RST_BUSY_TICKS   = 17'd100000;
    localparam logic [2:0]  RST_MAX_ATTEMPTS = 3'd5;

    localparam logic [16:0] POLL_MAX = 17'h1FFFF;

    // reset pin state {driven, level}
    localparam logic [1:0] PIN_DRIVEN = 2'b10;
    localparam logic [1:0] PIN_HIGH   = 2'b01;

    // instruction bytes
    localparam logic [7:0] INS_ENABLE      = 8'hAC;
    localparam logic [7:0] INS_ECHO        = 8'h53;
    localparam logic [7:0] INS_LOAD_LO     = 8'h40;
    localparam logic [7:0] INS_LOAD_HI     = 8'h48;
    localparam logic [7:0] INS_COMMIT_FL   = 8'h4C;
    localparam logic [7:0] INS_LOAD_EE     = 8'hC1;
    localparam logic [7:0] INS_COMMIT_EE   = 8'hC2;
    localparam logic [7:0] INS_READ_LO     = 8'h20;
    localparam logic [7:0] INS_READ_HI     = 8'h28;
    localparam logic [7:0] INS_READ_EE     = 8'hA0;
    localparam logic [7:0] INS_SIGNATURE   = 8'h30;
    localparam logic [7:0] INS_POLL        = 8'hF0;
    localparam logic [7:0] INS_FILL        = 8'hFF;

    function automatic logic [7:0] instr_byte(
        input op_t         op,
        input logic [1:0]  sub,
        input logic [15:0] addr,
        input logic [15:0] data,
        input logic [1:0]  idx
    );
        logic       polling;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] res;
        polling = (sub == 2'd1);
        b0 = 8'h00;
        b1 = 8'h00;
        b2 = 8'h00;
        b3 = 8'h00;
        unique case (op)
            OP_ENTER:
            begin
                b0 = INS_ENABLE;
                b1 = INS_ECHO;
            end
            OP_WR_FLASH:
            begin
                b0 = polling ? INS_LOAD_HI : INS_LOAD_LO;
                b1 = addr[15:8];
                b2 = addr[7:0];
                b3 = polling ? data[15:8] : data[7:0];
            end
            OP_COMMIT_FLASH, OP_COMMIT_EEPROM:
            begin
                if (polling)
                begin
                    b0 = INS_POLL;
                end
                else
                begin
                    b0 = (op == OP_COMMIT_FLASH) ? INS_COMMIT_FL : INS_COMMIT_EE;
                    b1 = addr[15:8];
                    b2 = addr[7:0];
                end
            end
            OP_WR_EEPROM:
            begin
                b0 = INS_LOAD_EE;
                b1 = addr[15:8];
                b2 = addr[7:0];
                b3 = data[7:0];
            end
            OP_RD_FLASH:
            begin
                b0 = polling ? INS_READ_HI : INS_READ_LO;
                b1 = addr[15:8];
                b2 = addr[7:0];
            end
            OP_RD_EEPROM:
            begin
                b0 = INS_READ_EE;
                b1 = addr[15:8];
                b2 = addr[7:0];
                b3 = INS_FILL;
            end
            default:
            begin
                b0 = INS_SIGNATURE;
                b2 = {6'd0, sub};
            end
        endcase
        case (idx)
            2'd0:    res = b0;
            2'd1:    res = b1;
            2'd2:    res = b2;
            default: res = b3;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/avr_isp_front.sv =====
// ----------------------------------------------------------------------------
// avr_isp_front
// Input side: classifies each item and drops codes with no meaning.
// ----------------------------------------------------------------------------
module avr_isp_front
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [39:0]          s_axis_tdata,
    input  logic [3:0]           s_axis_tuser,
    input  logic                 queue_full,
    output logic                 push,
    output avr_isp_pkg::event_t  push_event
);

    avr_isp_pkg::op_t cmd;
    logic             keep;

    assign cmd = avr_isp_pkg::op_t'(s_axis_tuser);

    always_comb
    begin
        keep            = 1'b1;
        push_event.kind = avr_isp_pkg::EV_REQ;
        unique case (cmd) inside
            [avr_isp_pkg::OP_ENTER : avr_isp_pkg::OP_SIGNATURE]:
                push_event.kind = avr_isp_pkg::EV_REQ;
            avr_isp_pkg::OP_SPI_BYTE:
                push_event.kind = avr_isp_pkg::EV_BYTE;
            avr_isp_pkg::OP_TICK:
                push_event.kind = avr_isp_pkg::EV_TICK;
            default:
                keep = 1'b0;
        endcase
        push_event.op      = cmd;
        push_event.address = s_axis_tdata[15:0];
        push_event.data    = s_axis_tdata[31:16];
        push_event.rx      = s_axis_tdata[39:32];
    end

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full && keep;

endmodule

// ===== rtl/avr_isp_queue.sv =====
// ----------------------------------------------------------------------------
// avr_isp_queue
// Short flip-flop FIFO between the front and the sequencer.
// ----------------------------------------------------------------------------
module avr_isp_queue
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign valid     = (count_reg != '0);
    assign head_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> valid)
        else $error("queue popped while empty");
    assert property (@(posedge clk) disable iff (!rst_n) push |-> (!full || pop))
        else $error("queue pushed while full");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

// ===== rtl/avr_isp_back.sv =====
// ----------------------------------------------------------------------------
// avr_isp_back
// Sequencer: runs enter/exit, instruction bytes, polling and the result register.
// ----------------------------------------------------------------------------
module avr_isp_back
#(
    parameter int SIGNATURE_BYTES = 3
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [avr_isp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [avr_isp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                 q_valid,
    input  avr_isp_pkg::event_t                  q_event,
    output logic                                 pop,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [39:0]                          m_axis_tdata,  // tx_byte, reset_driven,
                                                                // reset_level, spi_on, error,
                                                                // read_data, zero pad
    output logic [1:0]                           m_axis_tuser   // kind
);

    localparam logic [1:0] SIG_LAST = 2'(SIGNATURE_BYTES);

    // configuration
    logic [9:0]  pulse_ticks_reg;
    logic [16:0] settle_ticks_reg;
    logic [16:0] busy_ticks_reg;
    logic [2:0]  max_att_reg;

    // sequencer state
    avr_isp_pkg::phase_t phase_reg, phase_next;
    avr_isp_pkg::op_t    pending_reg, pending_next;
    logic [1:0]  bi_reg, bi_next;
    logic [1:0]  sub_reg, sub_next;
    logic [2:0]  att_reg, att_next;
    logic [16:0] wait_reg, wait_next;
    logic [16:0] poll_reg, poll_next;
    logic [7:0]  echo_reg, echo_next;
    logic [23:0] accum_reg, accum_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] data_reg, data_next;
    logic [1:0]  pin_reg, pin_next;
    logic        spi_reg, spi_next;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [39:0] m_data_reg;
    logic [1:0]  m_user_reg;

    // decode
    logic        req_go, exit_go, enter_go, rw_go;
    logic        byte_go, byte_mid, byte_last;
    logic        tick_go, pulse_end, settle_end, poll_tick;
    logic [17:0] wait_inc;
    logic [17:0] pulse_lim, settle_lim;
    logic [16:0] busy_lim;
    logic [2:0]  att_lim, att_inc;

    // end-of-instruction outcome
    logic        d_finish, d_err, d_pulse, d_next, d_poll_clr, d_att;
    logic [1:0]  d_sub;
    logic [23:0] d_accum, d_rd;
    logic [1:0]  sig_sub;

    // result being produced
    logic                    emit;
    avr_isp_pkg::res_kind_t  emit_kind;
    logic                    emit_err;
    logic [23:0]             emit_rd;
    logic [7:0]              emit_tx;

    assign pop = q_valid && (!m_valid_reg || m_axis_tready);

    assign req_go   = pop && (q_event.kind == avr_isp_pkg::EV_REQ)
                      && (phase_reg == avr_isp_pkg::PH_IDLE);
    assign exit_go  = req_go && (q_event.op == avr_isp_pkg::OP_EXIT);
    assign enter_go = req_go && (q_event.op == avr_isp_pkg::OP_ENTER);
    assign rw_go    = req_go && !exit_go && !enter_go;

    assign byte_go   = pop && (q_event.kind == avr_isp_pkg::EV_BYTE)
                       && (phase_reg == avr_isp_pkg::PH_XFER);
    assign byte_mid  = byte_go && (bi_reg != 2'd3);
    assign byte_last = byte_go && (bi_reg == 2'd3);

    assign tick_go    = pop && (q_event.kind == avr_isp_pkg::EV_TICK);
    assign wait_inc   = {1'b0, wait_reg} + 18'd1;
    assign pulse_lim  = (pulse_ticks_reg == '0) ? 18'd1 : {8'd0, pulse_ticks_reg};
    assign settle_lim = (settle_ticks_reg == '0) ? 18'd1 : {1'b0, settle_ticks_reg};
    assign busy_lim   = (busy_ticks_reg == '0) ? 17'd1 : busy_ticks_reg;
    assign att_lim    = (max_att_reg == '0) ? 3'd1 : max_att_reg;
    assign att_inc    = att_reg + 3'd1;

    assign pulse_end  = tick_go && (phase_reg == avr_isp_pkg::PH_PULSE)
                        && (wait_inc >= pulse_lim);
    assign settle_end = tick_go && (phase_reg == avr_isp_pkg::PH_SETTLE)
                        && (wait_inc >= settle_lim);
    assign poll_tick  = tick_go && (phase_reg == avr_isp_pkg::PH_XFER) && (sub_reg == 2'd1)
                        && ((pending_reg == avr_isp_pkg::OP_COMMIT_FLASH)
                            || (pending_reg == avr_isp_pkg::OP_COMMIT_EEPROM));

    assign sig_sub = sub_reg + 2'd1;

    // outcome of the fourth byte of an instruction
    always_comb
    begin
        d_finish   = 1'b0;
        d_err      = 1'b0;
        d_pulse    = 1'b0;
        d_next     = 1'b0;
        d_poll_clr = 1'b0;
        d_att      = 1'b0;
        d_sub      = sub_reg;
        d_accum    = accum_reg;
        d_rd       = '0;
        unique case (pending_reg)
            avr_isp_pkg::OP_ENTER:
            begin
                if (echo_reg == avr_isp_pkg::INS_ECHO)
                begin
                    d_finish = 1'b1;
                end
                else
                begin
                    d_att = 1'b1;
                    if (att_inc >= att_lim)
                    begin
                        d_finish = 1'b1;
                        d_err    = 1'b1;
                    end
                    else
                    begin
                        d_pulse = 1'b1;
                    end
                end
            end
            avr_isp_pkg::OP_WR_FLASH:
            begin
                if (sub_reg == 2'd0)
                begin
                    d_sub  = 2'd1;
                    d_next = 1'b1;
                end
                else
                begin
                    d_finish = 1'b1;
                end
            end
            avr_isp_pkg::OP_COMMIT_FLASH, avr_isp_pkg::OP_COMMIT_EEPROM:
            begin
                if (sub_reg == 2'd0)
                begin
                    d_sub      = 2'd1;
                    d_poll_clr = 1'b1;
                    d_next     = 1'b1;
                end
                else if (!q_event.rx[0])
                begin
                    d_finish = 1'b1;
                end
                else if (poll_reg >= busy_lim)
                begin
                    d_finish = 1'b1;
                    d_err    = 1'b1;
                end
                else
                begin
                    d_next = 1'b1;
                end
            end
            avr_isp_pkg::OP_WR_EEPROM:
            begin
                d_finish = 1'b1;
            end
            avr_isp_pkg::OP_RD_FLASH:
            begin
                if (sub_reg == 2'd0)
                begin
                    d_accum = {16'd0, q_event.rx};
                    d_sub   = 2'd1;
                    d_next  = 1'b1;
                end
                else
                begin
                    d_accum  = {8'd0, q_event.rx, accum_reg[7:0]};
                    d_rd     = d_accum;
                    d_finish = 1'b1;
                end
            end
            avr_isp_pkg::OP_RD_EEPROM:
            begin
                d_accum  = {16'd0, q_event.rx};
                d_rd     = d_accum;
                d_finish = 1'b1;
            end
            default:
            begin
                d_accum = {accum_reg[15:0], q_event.rx};
                d_sub   = sig_sub;
                if ((sig_sub >= SIG_LAST) || (sig_sub == 2'd0))
                begin
                    d_rd     = d_accum;
                    d_finish = 1'b1;
                end
                else
                begin
                    d_next = 1'b1;
                end
            end
        endcase
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (enter_go)
        begin
            phase_next = avr_isp_pkg::PH_PULSE;
        end
        else if (rw_go)
        begin
            phase_next = avr_isp_pkg::PH_XFER;
        end
        else if (byte_last)
        begin
            if (d_finish)
            begin
                phase_next = avr_isp_pkg::PH_IDLE;
            end
            else if (d_pulse)
            begin
                phase_next = avr_isp_pkg::PH_PULSE;
            end
            else
            begin
                phase_next = avr_isp_pkg::PH_XFER;
            end
        end
        else if (pulse_end)
        begin
            phase_next = avr_isp_pkg::PH_SETTLE;
        end
        else if (settle_end)
        begin
            phase_next = avr_isp_pkg::PH_XFER;
        end
    end

    // datapath and result
    always_comb
    begin
        pending_next = pending_reg;
        bi_next      = bi_reg;
        sub_next     = sub_reg;
        att_next     = att_reg;
        wait_next    = wait_reg;
        poll_next    = poll_reg;
        echo_next    = echo_reg;
        accum_next   = accum_reg;
        addr_next    = addr_reg;
        data_next    = data_reg;
        pin_next     = pin_reg;
        spi_next     = spi_reg;
        emit         = 1'b0;
        emit_kind    = avr_isp_pkg::KIND_SPI;
        emit_err     = 1'b0;
        emit_rd      = '0;

        if (exit_go)
        begin
            spi_next  = 1'b0;
            pin_next  = avr_isp_pkg::PIN_HIGH;
            emit      = 1'b1;
            emit_kind = avr_isp_pkg::KIND_RESET;
        end
        else if (enter_go)
        begin
            pending_next = avr_isp_pkg::OP_ENTER;
            sub_next     = 2'd0;
            accum_next   = '0;
            att_next     = '0;
            spi_next     = 1'b1;
            pin_next     = avr_isp_pkg::PIN_DRIVEN | avr_isp_pkg::PIN_HIGH;
            wait_next    = '0;
            emit         = 1'b1;
            emit_kind    = avr_isp_pkg::KIND_RESET;
        end
        else if (rw_go)
        begin
            pending_next = q_event.op;
            sub_next     = 2'd0;
            accum_next   = '0;
            addr_next    = q_event.address;
            data_next    = q_event.data;
            bi_next      = 2'd0;
            emit         = 1'b1;
        end
        else if (byte_mid)
        begin
            if (bi_reg == 2'd2)
            begin
                echo_next = q_event.rx;
            end
            bi_next = bi_reg + 2'd1;
            emit    = 1'b1;
        end
        else if (byte_last)
        begin
            sub_next   = d_sub;
            accum_next = d_accum;
            if (d_poll_clr)
            begin
                poll_next = '0;
            end
            if (d_att)
            begin
                att_next = att_inc;
            end
            emit = 1'b1;
            if (d_finish)
            begin
                emit_kind = avr_isp_pkg::KIND_DONE;
                emit_err  = d_err;
                emit_rd   = d_rd;
            end
            else if (d_pulse)
            begin
                pin_next  = avr_isp_pkg::PIN_DRIVEN | avr_isp_pkg::PIN_HIGH;
                wait_next = '0;
                emit_kind = avr_isp_pkg::KIND_RESET;
            end
            else
            begin
                bi_next = 2'd0;
            end
        end
        else if (tick_go && (phase_reg == avr_isp_pkg::PH_PULSE))
        begin
            if (pulse_end)
            begin
                pin_next  = avr_isp_pkg::PIN_DRIVEN;
                wait_next = '0;
                emit      = 1'b1;
                emit_kind = avr_isp_pkg::KIND_RESET;
            end
            else
            begin
                wait_next = wait_inc[16:0];
            end
        end
        else if (tick_go && (phase_reg == avr_isp_pkg::PH_SETTLE))
        begin
            if (settle_end)
            begin
                wait_next = '0;
                sub_next  = 2'd0;
                bi_next   = 2'd0;
                emit      = 1'b1;
            end
            else
            begin
                wait_next = wait_inc[16:0];
            end
        end
        else if (poll_tick)
        begin
            if (poll_reg != avr_isp_pkg::POLL_MAX)
            begin
                poll_next = poll_reg + 17'd1;
            end
        end

        emit_tx = (emit_kind == avr_isp_pkg::KIND_SPI)
                  ? avr_isp_pkg::instr_byte(pending_next, sub_next, addr_next,
                                            data_next, bi_next)
                  : 8'h00;
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (pop && emit)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_ticks_reg  <= avr_isp_pkg::RST_PULSE_TICKS;
            settle_ticks_reg <= avr_isp_pkg::RST_SETTLE_TICKS;
            busy_ticks_reg   <= avr_isp_pkg::RST_BUSY_TICKS;
            max_att_reg      <= avr_isp_pkg::RST_MAX_ATTEMPTS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                avr_isp_pkg::CFG_RESET_PULSE:  pulse_ticks_reg  <= cfg_data[9:0];
                avr_isp_pkg::CFG_SETTLE:       settle_ticks_reg <= cfg_data[16:0];
                avr_isp_pkg::CFG_BUSY_TIMEOUT: busy_ticks_reg   <= cfg_data[16:0];
                default:                       max_att_reg      <= cfg_data[2:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= avr_isp_pkg::PH_IDLE;
            pending_reg <= avr_isp_pkg::OP_ENTER;
            bi_reg      <= '0;
            sub_reg     <= '0;
            att_reg     <= '0;
            wait_reg    <= '0;
            poll_reg    <= '0;
            echo_reg    <= '0;
            accum_reg   <= '0;
            addr_reg    <= '0;
            data_reg    <= '0;
            pin_reg     <= '0;
            spi_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            bi_reg      <= bi_next;
            sub_reg     <= sub_next;
            att_reg     <= att_next;
            wait_reg    <= wait_next;
            poll_reg    <= poll_next;
            echo_reg    <= echo_next;
            accum_reg   <= accum_next;
            addr_reg    <= addr_next;
            data_reg    <= data_next;
            pin_reg     <= pin_next;
            spi_reg     <= spi_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            m_data_reg <= {4'd0, emit_rd, emit_err, spi_next, pin_next[0], pin_next[1],
                           emit_tx};
            m_user_reg <= emit_kind;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == avr_isp_pkg::PH_PULSE)
        |-> (pin_reg == (avr_isp_pkg::PIN_DRIVEN | avr_isp_pkg::PIN_HIGH)))
        else $error("reset pin not driven high during pulse");
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == avr_isp_pkg::PH_SETTLE) |-> (pin_reg == avr_isp_pkg::PIN_DRIVEN))
        else $error("reset pin not driven low during settle");
    assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == avr_isp_pkg::PH_PULSE) || (phase_reg == avr_isp_pkg::PH_SETTLE))
        |-> spi_reg)
        else $error("spi off while entering programming mode");

endmodule

// ===== rtl/avr_isp_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// avr_isp_command_sequencer
// Turns host requests into AVR serial-programming instruction bytes.
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser holds the command; tdata holds address, data and
// the received SPI byte. Requests start a sequence; SPI-byte items return
// what the last exchange shifted in; tick items mark 1 us of time.
// Output stream m_axis: tuser holds the kind (send byte, reset pin update,
// request done); tdata holds the byte to send, pin state, error flag and data.
// Each item yields at most one result. An item is taken every cycle while the
// input queue has room; a result is registered: the item waits in the queue and
// the output register loads as it leaves.
// The sequencer updates its state once per item, so with the receiver ready
// the sustained rate is one item per cycle. When the receiver stalls, the
// sequencer stops and the queue (QUEUE_DEPTH items) fills before s_axis_tready
// drops. Requests arriving while a sequence runs are discarded.
// Reset clears the queue, returns the sequencer to idle with SPI off and the
// target reset pin released, and loads the default timing registers.
// ----------------------------------------------------------------------------
module avr_isp_command_sequencer
#(
    parameter int QUEUE_DEPTH     = 4,
    parameter int SIGNATURE_BYTES = 3
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [avr_isp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [avr_isp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [39:0]                        s_axis_tdata,  // address, data, rx_byte
    input  logic [3:0]                         s_axis_tuser,  // cmd
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [39:0]                        m_axis_tdata,  // tx_byte, reset_driven,
                                                              // reset_level, spi_on, error,
                                                              // read_data, zero pad
    output logic [1:0]                         m_axis_tuser   // kind
);

    localparam int EV_W = $bits(avr_isp_pkg::event_t);

    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_valid;
    avr_isp_pkg::event_t  push_event;
    avr_isp_pkg::event_t  head_event;
    logic [EV_W-1:0]      head_bits;

    avr_isp_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (q_full),
        .push          (push),
        .push_event    (push_event)
    );

    avr_isp_queue
    #(
        .WIDTH (EV_W),
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_event),
        .pop       (pop),
        .full      (q_full),
        .valid     (q_valid),
        .head_data (head_bits)
    );

    assign head_event = avr_isp_pkg::event_t'(head_bits);

    avr_isp_back
    #(
        .SIGNATURE_BYTES (SIGNATURE_BYTES)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_valid       (q_valid),
        .q_event       (head_event),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== verif/tb_avr_isp_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_avr_isp_command_sequencer
// Self-checking bench for the ISP instruction sequencer. Stimulus plays the
// host: it follows the predicted sequencer state to return SPI bytes and
// ticks in protocol order, with stray and ill-timed items mixed in. A
// scoreboard predicts every result item and compares it field by field.
// ----------------------------------------------------------------------------
module tb_avr_isp_command_sequencer;

    import avr_isp_pkg::*;

    localparam int SIG_BYTES = 3;

    typedef struct {
        res_kind_t   kind;
        logic [7:0]  tx;
        logic        drv;
        logic        lvl;
        logic        spi;
        logic        err;
        logic [23:0] rd;
    } isp_result_t;

    class isp_scoreboard #(int SIG_COUNT = 3);
        logic [9:0]  pulse_ticks;
        logic [16:0] settle_ticks;
        logic [16:0] busy_ticks;
        logic [2:0]  attempts_max;

        phase_t      phase;
        op_t         op;
        logic [1:0]  byte_idx;
        logic [1:0]  sub;
        logic [2:0]  attempts;
        logic [16:0] wait_cnt;
        logic [16:0] poll_cnt;
        logic [7:0]  echo;
        logic [23:0] accum;
        logic [15:0] addr;
        logic [15:0] data;
        logic [1:0]  pin;
        logic        spi;

        isp_result_t awaited[$];
        int          errors;

        function new();
            set_timing(RST_PULSE_TICKS, RST_SETTLE_TICKS, RST_BUSY_TICKS, RST_MAX_ATTEMPTS);
            phase    = PH_IDLE;
            op       = OP_ENTER;
            byte_idx = 2'd0;
            sub      = 2'd0;
            attempts = 3'd0;
            wait_cnt = 17'd0;
            poll_cnt = 17'd0;
            echo     = 8'd0;
            accum    = 24'd0;
            addr     = 16'd0;
            data     = 16'd0;
            pin      = 2'b00;
            spi      = 1'b0;
            errors   = 0;
        endfunction

        function void set_timing(logic [9:0] p, logic [16:0] s, logic [16:0] b, logic [2:0] a);
            pulse_ticks  = p;
            settle_ticks = s;
            busy_ticks   = b;
            attempts_max = a;
        endfunction

        // zero count behaves as one
        function logic [16:0] floor_one(logic [16:0] v);
            return (v == 17'd0) ? 17'd1 : v;
        endfunction

        function void push(res_kind_t k, logic [7:0] tx, logic err, logic [23:0] rd);
            isp_result_t r;
            r.kind = k;
            r.tx   = tx;
            r.drv  = pin[1];
            r.lvl  = pin[0];
            r.spi  = spi;
            r.err  = err;
            r.rd   = rd;
            awaited.push_back(r);
        endfunction

        function logic [7:0] frame_byte(logic [1:0] idx);
            logic        poll;
            logic [31:0] w;
            poll = (sub == 2'd1);
            case (op)
                OP_ENTER:
                    w = {INS_ENABLE, INS_ECHO, 16'h0000};
                OP_WR_FLASH:
                    w = {poll ? INS_LOAD_HI : INS_LOAD_LO, addr,
                         poll ? data[15:8] : data[7:0]};
                OP_COMMIT_FLASH, OP_COMMIT_EEPROM:
                begin
                    if (poll)
                        w = {INS_POLL, 24'h000000};
                    else
                        w = {(op == OP_COMMIT_FLASH) ? INS_COMMIT_FL : INS_COMMIT_EE,
                             addr, 8'h00};
                end
                OP_WR_EEPROM:
                    w = {INS_LOAD_EE, addr, data[7:0]};
                OP_RD_FLASH:
                    w = {poll ? INS_READ_HI : INS_READ_LO, addr, 8'h00};
                OP_RD_EEPROM:
                    w = {INS_READ_EE, addr, INS_FILL};
                default:
                    w = {INS_SIGNATURE, 8'h00, 6'd0, sub, 8'h00};
            endcase
            return w[31 - 8 * idx -: 8];
        endfunction

        function void start_frame();
            phase    = PH_XFER;
            byte_idx = 2'd0;
            push(KIND_SPI, frame_byte(2'd0), 1'b0, 24'd0);
        endfunction

        function void finish(logic err, logic [23:0] rd);
            phase = PH_IDLE;
            push(KIND_DONE, 8'h00, err, rd);
        endfunction

        function void start_pulse();
            pin      = PIN_DRIVEN | PIN_HIGH;
            phase    = PH_PULSE;
            wait_cnt = 17'd0;
            push(KIND_RESET, 8'h00, 1'b0, 24'd0);
        endfunction

        function void frame_done(logic [7:0] rx);
            case (op)
                OP_ENTER:
                begin
                    if (echo == INS_ECHO)
                        finish(1'b0, 24'd0);
                    else
                    begin
                        attempts = attempts + 3'd1;
                        if ({14'd0, attempts} >= floor_one({14'd0, attempts_max}))
                            finish(1'b1, 24'd0);
                        else
                            start_pulse();
                    end
                end
                OP_WR_FLASH:
                begin
                    if (sub == 2'd0)
                    begin
                        sub = 2'd1;
                        start_frame();
                    end
                    else
                        finish(1'b0, 24'd0);
                end
                OP_COMMIT_FLASH, OP_COMMIT_EEPROM:
                begin
                    if (sub == 2'd0)
                    begin
                        sub      = 2'd1;
                        poll_cnt = 17'd0;
                        start_frame();
                    end
                    else if (!rx[0])
                        finish(1'b0, 24'd0);
                    else if (poll_cnt >= floor_one(busy_ticks))
                        finish(1'b1, 24'd0);
                    else
                        start_frame();
                end
                OP_WR_EEPROM:
                    finish(1'b0, 24'd0);
                OP_RD_FLASH:
                begin
                    if (sub == 2'd0)
                    begin
                        accum = {16'd0, rx};
                        sub   = 2'd1;
                        start_frame();
                    end
                    else
                    begin
                        accum = {8'd0, rx, accum[7:0]};
                        finish(1'b0, accum);
                    end
                end
                OP_RD_EEPROM:
                begin
                    accum = {16'd0, rx};
                    finish(1'b0, accum);
                end
                default:
                begin
                    accum = {accum[15:0], rx};
                    sub   = sub + 2'd1;
                    if (sub >= SIG_COUNT || sub == 2'd0)
                        finish(1'b0, accum);
                    else
                        start_frame();
                end
            endcase
        endfunction

        // returns 1 when the item gives a result
        function bit note_item(logic [3:0] cmd, logic [15:0] a, logic [15:0] d, logic [7:0] rx);
            int before_cnt;
            before_cnt = awaited.size();
            if (cmd <= OP_SIGNATURE)
            begin
                if (phase == PH_IDLE)
                begin
                    if (cmd == OP_EXIT)
                    begin
                        spi = 1'b0;
                        pin = PIN_HIGH;
                        push(KIND_RESET, 8'h00, 1'b0, 24'd0);
                    end
                    else
                    begin
                        op    = op_t'(cmd);
                        sub   = 2'd0;
                        accum = 24'd0;
                        if (cmd == OP_ENTER)
                        begin
                            attempts = 3'd0;
                            spi      = 1'b1;
                            start_pulse();
                        end
                        else
                        begin
                            addr = a;
                            data = d;
                            start_frame();
                        end
                    end
                end
            end
            else if (cmd == OP_SPI_BYTE)
            begin
                if (phase == PH_XFER)
                begin
                    if (byte_idx == 2'd2)
                        echo = rx;
                    if (byte_idx < 2'd3)
                    begin
                        byte_idx = byte_idx + 2'd1;
                        push(KIND_SPI, frame_byte(byte_idx), 1'b0, 24'd0);
                    end
                    else
                        frame_done(rx);
                end
            end
            else if (cmd == OP_TICK)
            begin
                if (phase == PH_PULSE)
                begin
                    wait_cnt = wait_cnt + 17'd1;
                    if (wait_cnt >= floor_one({7'd0, pulse_ticks}))
                    begin
                        pin      = PIN_DRIVEN;
                        phase    = PH_SETTLE;
                        wait_cnt = 17'd0;
                        push(KIND_RESET, 8'h00, 1'b0, 24'd0);
                    end
                end
                else if (phase == PH_SETTLE)
                begin
                    wait_cnt = wait_cnt + 17'd1;
                    if (wait_cnt >= floor_one(settle_ticks))
                    begin
                        wait_cnt = 17'd0;
                        sub      = 2'd0;
                        start_frame();
                    end
                end
                else if (phase == PH_XFER && sub == 2'd1 &&
                         (op == OP_COMMIT_FLASH || op == OP_COMMIT_EEPROM))
                begin
                    if (poll_cnt < POLL_MAX)
                        poll_cnt = poll_cnt + 17'd1;
                end
            end
            return awaited.size() != before_cnt;
        endfunction

        function void compare(string field, logic [23:0] want, logic [23:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %h got %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] user, logic [39:0] word);
            isp_result_t e;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d data %h", $time, user, word);
                errors++;
                return;
            end
            e = awaited.pop_front();
            compare("kind", {22'd0, e.kind}, {22'd0, user});
            compare("tx_byte", {16'd0, e.tx}, {16'd0, word[7:0]});
            compare("reset_driven", {23'd0, e.drv}, {23'd0, word[8]});
            compare("reset_level", {23'd0, e.lvl}, {23'd0, word[9]});
            compare("spi_on", {23'd0, e.spi}, {23'd0, word[10]});
            compare("error", {23'd0, e.err}, {23'd0, word[11]});
            compare("read_data", e.rd, word[35:12]);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata = '0;
    logic [3:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    isp_scoreboard #(SIG_BYTES) sb;

    int gap_pct       = 0;
    int stall_pct     = 0;
    int echo_ok_pct   = 100;
    int busy_pct      = 0;
    int poll_tick_pct = 33;

    avr_isp_command_sequencer #(.SIGNATURE_BYTES(SIG_BYTES)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    task automatic send_item(input logic [3:0] cmd, input logic [15:0] a, input logic [15:0] d,
                             input logic [7:0] rx, output bit produced);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rx, d, a};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        produced = sb.note_item(cmd, a, d, rx);
    endtask

    // host side: next item in protocol order for the predicted state
    function automatic void pick_next(input bit noisy, output logic [3:0] cmd,
                                      output logic [15:0] a, output logic [15:0] d,
                                      output logic [7:0] rx);
        int  r;
        bit  polling;
        a  = 16'($urandom);
        d  = 16'($urandom);
        rx = 8'($urandom);
        polling = sb.sub == 2'd1 && (sb.op == OP_COMMIT_FLASH || sb.op == OP_COMMIT_EEPROM);
        if (noisy && $urandom_range(0, 99) < 8)
            cmd = 4'($urandom_range(0, 15));
        else if (sb.phase == PH_IDLE)
        begin
            r = $urandom_range(0, 9);
            if (r == 9)
                cmd = OP_ENTER;
            else
                cmd = 4'(r);
        end
        else if (sb.phase != PH_XFER)
            cmd = OP_TICK;
        else if (polling && $urandom_range(0, 99) < poll_tick_pct)
            cmd = OP_TICK;
        else
        begin
            cmd = OP_SPI_BYTE;
            if (sb.op == OP_ENTER && sb.byte_idx == 2'd2 &&
                $urandom_range(0, 99) < echo_ok_pct)
                rx = INS_ECHO;
            if (polling && sb.byte_idx == 2'd3)
                rx[0] = $urandom_range(0, 99) < busy_pct;
        end
    endfunction

    task automatic drive_until_idle();
        logic [3:0]  c;
        logic [15:0] a;
        logic [15:0] d;
        logic [7:0]  rx;
        bit          hit;
        while (sb.phase != PH_IDLE)
        begin
            pick_next(1'b0, c, a, d, rx);
            send_item(c, a, d, rx, hit);
        end
    endtask

    task automatic request(input logic [3:0] cmd, input logic [15:0] a, input logic [15:0] d);
        bit hit;
        send_item(cmd, a, d, 8'($urandom), hit);
        drive_until_idle();
    endtask

    // idle block: all results in, queue flushed of items that give none
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic load_timing(input logic [9:0] p, input logic [16:0] s, input logic [16:0] b,
                               input logic [2:0] a);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RESET_PULSE;
        cfg_data  <= {7'd0, p};
        @(posedge clk);
        cfg_index <= CFG_SETTLE;
        cfg_data  <= s;
        @(posedge clk);
        cfg_index <= CFG_BUSY_TIMEOUT;
        cfg_data  <= b;
        @(posedge clk);
        cfg_index <= CFG_MAX_ATTEMPTS;
        cfg_data  <= {14'd0, a};
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_timing(p, s, b, a);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata);
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        #40000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [3:0]  c;
        logic [15:0] a;
        logic [15:0] d;
        logic [7:0]  rx;
        bit          hit;
        int          sent;

        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default timing; no enter here as settle is long
        request(OP_SIGNATURE, 16'h0000, 16'h0000);
        request(OP_RD_FLASH, 16'hFFFF, 16'hFFFF);
        request(OP_RD_FLASH, 16'h0000, 16'h0000);
        request(OP_WR_FLASH, 16'hFFFF, 16'hFFFF);
        request(OP_WR_FLASH, 16'h0000, 16'h0000);
        request(OP_WR_EEPROM, 16'h5AA5, 16'h00FF);
        request(OP_RD_EEPROM, 16'hA55A, 16'hFF00);
        request(OP_COMMIT_FLASH, 16'h1234, 16'h0000);
        busy_pct = 60;
        request(OP_COMMIT_EEPROM, 16'hFEDC, 16'h0000);
        request(OP_EXIT, 16'h0000, 16'h0000);
        // stray items in idle
        request(OP_SPI_BYTE, 16'h0000, 16'h0000);
        request(OP_TICK, 16'h0000, 16'h0000);
        request(4'd11, 16'hFFFF, 16'hFFFF);
        request(4'd15, 16'h0000, 16'h0000);

        // all-zero registers act as one
        drain();
        load_timing(10'd0, 17'd0, 17'd0, 3'd0);
        echo_ok_pct = 0;
        request(OP_ENTER, 16'h0000, 16'h0000);
        echo_ok_pct = 100;
        send_item(OP_ENTER, 16'h0000, 16'h0000, 8'h00, hit);
        send_item(OP_RD_FLASH, 16'h1111, 16'h2222, 8'h00, hit);
        drive_until_idle();
        busy_pct = 100;
        request(OP_COMMIT_FLASH, 16'h00FF, 16'h0000);

        // echo byte left random, so enable attempts fail unless it matches
        drain();
        load_timing(10'd1, 17'd1, 17'd1, 3'd7);
        echo_ok_pct = 0;
        request(OP_ENTER, 16'h0000, 16'h0000);

        // longer waits: multi-tick pulse and settle, busy until timeout
        drain();
        load_timing(10'd24, 17'd40, 17'd30, 3'd7);
        echo_ok_pct = 100;
        request(OP_ENTER, 16'h0000, 16'h0000);
        poll_tick_pct = 99;
        request(OP_COMMIT_EEPROM, 16'hFFFF, 16'h0000);
        poll_tick_pct = 33;

        echo_ok_pct = 67;
        busy_pct    = 50;
        for (int m = 0; m < 4; m++)
        begin
            drain();
            load_timing(($urandom_range(0, 7) == 0) ? 10'd0 : 10'($urandom_range(1, 4)),
                        ($urandom_range(0, 7) == 0) ? 17'd0 : 17'($urandom_range(1, 5)),
                        ($urandom_range(0, 7) == 0) ? 17'd0 : 17'($urandom_range(1, 6)),
                        3'($urandom_range(0, 7)));
            gap_pct   = (m == 1) ? 81 : (m == 3) ? 38 : 0;
            stall_pct = (m == 2) ? 81 : (m == 3) ? 38 : 0;
            sent      = 0;
            while (sent < 220)
            begin
                pick_next(1'b1, c, a, d, rx);
                send_item(c, a, d, rx, hit);
                sent++;
            end
            drive_until_idle();
        end

        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
